// ----- src/sql_last_statement_split_scanner_assert.svh -----
// Assertion macros for the SQL statement split scanner.
// Used by the top level only; no other dependencies.
`ifndef SQL_LAST_STATEMENT_SPLIT_SCANNER_ASSERT_SVH
`define SQL_LAST_STATEMENT_SPLIT_SCANNER_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define SLSS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define SLSS_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ----- src/slss_pkg.sv -----
// Package for the SQL statement split scanner: scan state types, byte codes
// and small byte classifiers. Used by slss_step and the top level.
`default_nettype none

package slss_pkg;

    // Field widths of the stream words.
    localparam int TEXT_BYTE_W     = 8;
    localparam int SPLIT_OFFSET_W  = 17;
    localparam int IN_TDATA_W      = 8;
    localparam int OUT_TDATA_W     = 24;
    localparam int OUT_TUSER_W     = 1;

    // Byte codes that steer the scanner.
    localparam logic [TEXT_BYTE_W-1:0] CH_DASH    = 8'h2D;
    localparam logic [TEXT_BYTE_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [TEXT_BYTE_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [TEXT_BYTE_W-1:0] CH_SEMI    = 8'h3B;
    localparam logic [TEXT_BYTE_W-1:0] CH_SQUOTE  = 8'h27;
    localparam logic [TEXT_BYTE_W-1:0] CH_DQUOTE  = 8'h22;
    localparam logic [TEXT_BYTE_W-1:0] CH_BTICK   = 8'h60;
    localparam logic [TEXT_BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [TEXT_BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [TEXT_BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [TEXT_BYTE_W-1:0] CH_CR      = 8'h0D;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_LINE,
        MODE_BLOCK,
        MODE_QUOTE
    } t_scan_mode;

    typedef enum logic [1:0] {
        QUOTE_NONE,
        QUOTE_SINGLE,
        QUOTE_DOUBLE,
        QUOTE_BACKTICK
    } t_quote;

    typedef enum logic [1:0] {
        HELD_NONE,
        HELD_DASH,
        HELD_SLASH
    } t_held;

    // Mode state of the scanner, apart from positions.
    typedef struct packed {
        t_scan_mode mode;
        t_quote     quote;
        logic       close_seen;
        t_held      held;
        logic       star_seen;
    } t_scan_state;

    // What one byte does to the split tracking.
    typedef struct packed {
        logic content;
        logic semicolon;
    } t_scan_evt;

    localparam t_scan_state SCAN_RESET = '{
        mode:       MODE_NORMAL,
        quote:      QUOTE_NONE,
        close_seen: 1'b0,
        held:       HELD_NONE,
        star_seen:  1'b0
    };

    // Quote kind that a byte opens or closes.
    function automatic t_quote quote_of(input logic [TEXT_BYTE_W-1:0] b);
        t_quote q;
        q = QUOTE_NONE;
        if (b == CH_SQUOTE) begin
            q = QUOTE_SINGLE;
        end else if (b == CH_DQUOTE) begin
            q = QUOTE_DOUBLE;
        end else if (b == CH_BTICK) begin
            q = QUOTE_BACKTICK;
        end
        return q;
    endfunction

    // Space, tab, newline, vertical tab, form feed and carriage return.
    function automatic logic is_blank(input logic [TEXT_BYTE_W-1:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

`default_nettype wire

// ----- src/slss_step.sv -----
// One-byte step of the SQL split scanner: next mode state and split events.
// Depends on slss_pkg.
`default_nettype none

module slss_step (
    input  wire  slss_pkg::t_scan_state          i_state,
    input  wire  [slss_pkg::TEXT_BYTE_W-1:0]     i_byte,
    output slss_pkg::t_scan_state                o_state,
    output slss_pkg::t_scan_evt                  o_evt
);
    import slss_pkg::*;

    t_quote byte_quote;
    logic   run_normal;
    logic   pair_dash;
    logic   pair_slash;
    logic   comment_open;

    // The byte is seen by normal text either directly or right after a quote closes.
    assign byte_quote   = quote_of(i_byte);
    assign run_normal   = (i_state.mode == MODE_NORMAL) ||
                          ((i_state.mode == MODE_QUOTE) && i_state.close_seen &&
                           (byte_quote != i_state.quote));
    assign pair_dash    = (i_state.held == HELD_DASH) && (i_byte == CH_DASH);
    assign pair_slash   = (i_state.held == HELD_SLASH) && (i_byte == CH_STAR);
    assign comment_open = pair_dash || pair_slash;

    // Next mode state.
    always_comb begin
        o_state = i_state;
        unique case (i_state.mode)
            MODE_LINE: begin
                if (i_byte == CH_NEWLINE) begin
                    o_state.mode = MODE_NORMAL;
                end
            end
            MODE_BLOCK: begin
                if (i_state.star_seen && (i_byte == CH_SLASH)) begin
                    o_state.mode      = MODE_NORMAL;
                    o_state.star_seen = 1'b0;
                end else begin
                    o_state.star_seen = (i_byte == CH_STAR);
                end
            end
            MODE_QUOTE: begin
                if (i_state.close_seen) begin
                    o_state.close_seen = 1'b0;
                    if (byte_quote != i_state.quote) begin
                        o_state.mode = MODE_NORMAL;
                    end
                end else if (byte_quote == i_state.quote) begin
                    o_state.close_seen = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Normal text handling, including the held dash or slash.
        if (run_normal) begin
            o_state.held = HELD_NONE;
            if (pair_dash) begin
                o_state.mode = MODE_LINE;
            end else if (pair_slash) begin
                o_state.mode      = MODE_BLOCK;
                o_state.star_seen = 1'b0;
            end else if (i_byte == CH_DASH) begin
                o_state.held = HELD_DASH;
            end else if (i_byte == CH_SLASH) begin
                o_state.held = HELD_SLASH;
            end else if (byte_quote != QUOTE_NONE) begin
                o_state.mode       = MODE_QUOTE;
                o_state.quote      = byte_quote;
                o_state.close_seen = 1'b0;
            end
        end
    end

    // Split events: content confirms a pending split, a semicolon starts one.
    always_comb begin
        o_evt = '0;
        if (run_normal && !comment_open) begin
            o_evt.content   = (i_state.held != HELD_NONE) ||
                              ((i_byte != CH_DASH) && (i_byte != CH_SLASH) &&
                               !is_blank(i_byte));
            o_evt.semicolon = (i_byte == CH_SEMI);
        end
    end

endmodule

`default_nettype wire

// ----- src/sql_last_statement_split_scanner.sv -----
// Top level of the SQL statement split scanner: stream ports, offset tracking
// and the result register. Depends on slss_pkg, slss_step and the assert header.
//
// Usage:
//   SQL text enters on the s_axis channel, one byte per word, with tlast on
//   the last byte of a text. Each text yields exactly one word on m_axis:
//   tuser[0] says whether a semicolon followed by real content was found,
//   and tdata holds the offset just past the last such semicolon (zero when
//   none). Offsets saturate at MAX_TEXT_BYTES and are carried in 17 bits.
//   Every byte is scanned in the cycle it is accepted; the result word is
//   valid in the cycle after the last byte is accepted. One byte per cycle
//   is taken, back to back, across text boundaries: the next text starts
//   scanning from reset state right after its predecessor's last byte.
//   The result register holds one word. While it is full and m_axis_tready
//   is low, s_axis_tready drops on a final byte, so it waits without loss.
//   Bytes that do not end a text are accepted even while a result waits.
//   Synchronous active-low reset clears the scan state and the result valid.
`default_nettype none

module sql_last_statement_split_scanner #(
    parameter int MAX_TEXT_BYTES = 65536
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: [7:0] text_byte
    input  wire  [slss_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // tlast: is_final
    input  wire                                   s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // tdata: [16:0] split_offset, [23:17] zero
    output logic [slss_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: [0] split_found
    output logic [slss_pkg::OUT_TUSER_W-1:0]      m_axis_tuser
);
    import slss_pkg::*;

    localparam int POS_W = $clog2(MAX_TEXT_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TEXT_BYTES);

    t_scan_state r_state, n_state, step_state;
    t_scan_evt   step_evt;

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_pend_v, n_pend_v;
    logic [POS_W-1:0] r_pend_off, n_pend_off;
    logic             r_comm_v, n_comm_v;
    logic [POS_W-1:0] r_comm_off, n_comm_off;

    logic                      r_out_v, n_out_v;
    logic                      r_out_found, n_out_found;
    logic [SPLIT_OFFSET_W-1:0] r_out_off, n_out_off;

    logic                      in_acc;
    logic                      out_acc;
    logic [POS_W-1:0]          pos_next;
    logic                      commit;
    logic                      step_pend_v;
    logic [POS_W-1:0]          step_pend_off;
    logic                      step_comm_v;
    logic [POS_W-1:0]          step_comm_off;
    logic                      tail_commit;
    logic                      res_found;
    logic [POS_W-1:0]          res_off;
    logic [POS_W+SPLIT_OFFSET_W-1:0] res_off_wide;

    // Handshakes: a byte is taken unless a final result would find the register full.
    assign out_acc       = r_out_v && m_axis_tready;
    assign s_axis_tready = !r_out_v || m_axis_tready || !s_axis_tlast;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    slss_step u_step (
        .i_state (r_state),
        .i_byte  (s_axis_tdata[TEXT_BYTE_W-1:0]),
        .o_state (step_state),
        .o_evt   (step_evt)
    );

    // Saturating byte position; it is also the offset past this byte.
    assign pos_next = (r_pos == POS_MAX) ? POS_MAX : r_pos + POS_W'(1);

    // Pending and committed split after this byte.
    assign commit = step_evt.content && r_pend_v;
    always_comb begin
        step_pend_v   = r_pend_v;
        step_pend_off = r_pend_off;
        step_comm_v   = r_comm_v;
        step_comm_off = r_comm_off;
        if (commit) begin
            step_comm_v   = 1'b1;
            step_comm_off = r_pend_off;
            step_pend_v   = 1'b0;
        end
        if (step_evt.semicolon) begin
            step_pend_v   = 1'b1;
            step_pend_off = pos_next;
        end
    end

    // A dash or slash still held at the end of a text counts as content.
    assign tail_commit  = (step_state.mode == MODE_NORMAL) &&
                          (step_state.held != HELD_NONE) && step_pend_v;
    assign res_found    = tail_commit || step_comm_v;
    assign res_off      = !res_found ? '0 : (tail_commit ? step_pend_off : step_comm_off);
    assign res_off_wide = {{SPLIT_OFFSET_W{1'b0}}, res_off};

    // Scan state update; the final byte returns everything to reset.
    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_pend_v   = r_pend_v;
        n_pend_off = r_pend_off;
        n_comm_v   = r_comm_v;
        n_comm_off = r_comm_off;
        if (in_acc) begin
            if (s_axis_tlast) begin
                n_state    = SCAN_RESET;
                n_pos      = '0;
                n_pend_v   = 1'b0;
                n_pend_off = '0;
                n_comm_v   = 1'b0;
                n_comm_off = '0;
            end else begin
                n_state    = step_state;
                n_pos      = pos_next;
                n_pend_v   = step_pend_v;
                n_pend_off = step_pend_off;
                n_comm_v   = step_comm_v;
                n_comm_off = step_comm_off;
            end
        end
    end

    // Result register.
    always_comb begin
        n_out_v     = r_out_v && !out_acc;
        n_out_found = r_out_found;
        n_out_off   = r_out_off;
        if (in_acc && s_axis_tlast) begin
            n_out_v     = 1'b1;
            n_out_found = res_found;
            n_out_off   = res_off_wide[SPLIT_OFFSET_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= SCAN_RESET;
            r_pos      <= '0;
            r_pend_v   <= 1'b0;
            r_pend_off <= '0;
            r_comm_v   <= 1'b0;
            r_comm_off <= '0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_pend_v   <= n_pend_v;
            r_pend_off <= n_pend_off;
            r_comm_v   <= n_comm_v;
            r_comm_off <= n_comm_off;
            r_out_v    <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_found <= n_out_found;
        r_out_off   <= n_out_off;
    end

    // Output ports.
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {{(OUT_TDATA_W - SPLIT_OFFSET_W){1'b0}}, r_out_off};
    assign m_axis_tuser  = r_out_found;

    // Checks on the scanner's own bookkeeping.
`include "sql_last_statement_split_scanner_assert.svh"

    `SLSS_ASSERT_NEXT(a_final_resets, i_clk, i_rst_n, in_acc && s_axis_tlast, (r_pos == '0) && !r_pend_v && !r_comm_v, "scan state not cleared after the last byte")
    `SLSS_ASSERT_ALWAYS(a_commit_in_range, i_clk, i_rst_n, !r_comm_v || ((r_comm_off != '0) && (r_comm_off <= r_pos)), "committed split lies outside the scanned text")
    `SLSS_ASSERT_ALWAYS(a_empty_result_zero, i_clk, i_rst_n, !r_out_v || r_out_found || (r_out_off == '0), "offset nonzero without a split")
    `SLSS_ASSERT_ALWAYS(a_stall_only_full, i_clk, i_rst_n, s_axis_tready || r_out_v, "input stalled while the result register is empty")

endmodule

`default_nettype wire
